### rtl/tle_pkg.sv
// Shared types and byte codes for the terminal line editor.
`timescale 1ns / 1ps
package tle_pkg;

  // Most results one received byte may produce; later ones are dropped.
  localparam int unsigned MaxResults = 40;

  localparam logic [7:0] ChEsc    = 8'h1b;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChCtrlA  = 8'h01;
  localparam logic [7:0] ChCtrlB  = 8'h02;
  localparam logic [7:0] ChCtrlC  = 8'h03;
  localparam logic [7:0] ChCtrlE  = 8'h05;
  localparam logic [7:0] ChCtrlF  = 8'h06;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTilde  = 8'h7e;
  localparam logic [7:0] ChUpperC = 8'h43;
  localparam logic [7:0] ChUpperD = 8'h44;
  localparam logic [7:0] ChFour   = 8'h34;

  typedef enum logic [3:0] {
    OP_RIGHT,
    OP_LEFT,
    OP_DEL,
    OP_BS,
    OP_ENTER,
    OP_CANCEL,
    OP_HOME,
    OP_END,
    OP_INSERT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } op_t;

  typedef enum logic [1:0] {
    K_ECHO   = 2'd0,
    K_LINE   = 2'd1,
    K_DONE   = 2'd2,
    K_CANCEL = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic [5:0] len;
  } res_t;

endpackage

### rtl/terminal_line_editor_top.sv
// Top level of the terminal line editor.
//
// Usage: received terminal bytes enter on s_axis (one byte per transfer).
// Each byte produces zero or more results on m_axis: tdata carries the echo
// or line byte and, on a completion marker, the line length; tuser carries
// the kind (echo, line character, line complete, line cancelled); tlast
// marks the final result of that byte. cfg_* writes the line limit, which the
// user must write only while the block is idle; the block does not enforce it.
// A front stage decodes bytes (including escape pairs) into edit operations
// and queues up to two of them; the engine runs one operation at a time.
// An insert or delete that moves the line store shifts it one character at a
// time (single-port store sequencing).
// Reset clears the line, cursor, escape flag and sets the limit to 32.
// When m_axis_tready_i is low while a result is pending, the engine holds in
// place; the queue keeps accepting bytes until it fills.
`timescale 1ns / 1ps
module terminal_line_editor_top #(
  parameter int unsigned LINE_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,       // line_limit
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // out_byte [7:0], line_length [13:8], zero
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o
);
  import tle_pkg::*;

  logic [5:0] line_limit_q;
  logic       push, push_ready, pop_valid, pop;
  op_t        push_op, pop_op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= 6'd32;
    end else if (cfg_valid_i) begin
      line_limit_q <= cfg_data_i;
    end
  end

  tle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .op_push_o      (push),
    .op_o           (push_op),
    .op_ready_i     (push_ready)
  );

  tle_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_op),
    .pop_i       (pop)
  );

  tle_engine #(.LINE_LEN(LINE_LEN)) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .line_limit_i   (line_limit_q),
    .op_valid_i     (pop_valid),
    .op_i           (pop_op),
    .op_pop_o       (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

### rtl/tle_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tle_fifo.sv
// Two-entry queue of decoded edit operations between front and engine.
`timescale 1ns / 1ps
module tle_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tle_pkg::op_t   push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output tle_pkg::op_t   pop_data_o,
  input  logic           pop_i
);
  import tle_pkg::*;

  op_t        mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tle_front.sv
// Input side: escape tracking and classification of received bytes.
`timescale 1ns / 1ps
module tle_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // rx_byte
  output logic          op_push_o,
  output tle_pkg::op_t  op_o,
  input  logic          op_ready_i
);
  import tle_pkg::*;

  logic esc_q, esc_d;
  logic take;
  logic known;
  op_e  op;
  logic [7:0] b;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = op_ready_i;
  assign take            = s_axis_tvalid_i && op_ready_i;

  always_comb begin
    known = 1'b1;
    op    = OP_INSERT;
    esc_d = esc_q;
    if (take) begin
      if (esc_q) begin
        esc_d = 1'b0;
        priority case (b)
          ChUpperC: op = OP_RIGHT;
          ChUpperD: op = OP_LEFT;
          ChFour:   op = OP_DEL;
          default:  known = 1'b0;
        endcase
      end else begin
        priority case (b)
          ChEsc: begin
            esc_d = 1'b1;
            known = 1'b0;
          end
          ChCtrlF: op = OP_RIGHT;
          ChCtrlB: op = OP_LEFT;
          ChBs:    op = OP_BS;
          ChLf:    op = OP_ENTER;
          ChCr:    op = OP_ENTER;
          ChCtrlC: op = OP_CANCEL;
          ChCtrlA: op = OP_HOME;
          ChCtrlE: op = OP_END;
          default: known = (b >= ChSpace) && (b <= ChTilde);
        endcase
      end
    end
  end

  assign op_push_o = take && known;
  assign op_o      = '{op: op, ch: b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

### rtl/tle_engine.sv
// Back end: line store, cursor sequencer and result output stage.
`timescale 1ns / 1ps
module tle_engine #(
  parameter int unsigned LINE_LEN = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [5:0]    line_limit_i,
  input  logic          op_valid_i,
  input  tle_pkg::op_t  op_i,
  output logic          op_pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [15:0]   m_axis_tdata_o,   // out_byte [7:0], line_length [13:8], zero
  output logic [1:0]    m_axis_tuser_o,   // kind
  output logic          m_axis_tlast_o
);
  import tle_pkg::*;

  localparam int unsigned CW = $clog2(LINE_LEN + 1);
  localparam int unsigned AW = $clog2(LINE_LEN);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOP, ST_SEQ, ST_MOVE, ST_PUT, ST_CH, ST_SHR,
    ST_BS, ST_SHL, ST_BS2, ST_BS3, ST_BS4, ST_ENT, ST_MARK, ST_FIN
  } state_e;

  // Echo snippets: " " BS CR LF "^C" CR LF
  localparam logic [2:0] SeqSp     = 3'd0;
  localparam logic [2:0] SeqBs     = 3'd1;
  localparam logic [2:0] SeqCrLf   = 3'd2;
  localparam logic [2:0] SeqCancel = 3'd4;

  function automatic logic [7:0] seq_byte(logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      3'd0:    r = ChSpace;
      3'd1:    r = ChBs;
      3'd2:    r = ChCr;
      3'd3:    r = ChLf;
      3'd4:    r = 8'h5e;
      3'd5:    r = ChUpperC;
      3'd6:    r = ChCr;
      default: r = ChLf;
    endcase
    return r;
  endfunction

  // Two decimal digits of a count below 100; tens by reciprocal multiply.
  function automatic logic [15:0] dec_digits(logic [6:0] n);
    logic [17:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = 18'(n) * 18'd205;
    t = p[14:11];
    o = n - 7'(t) * 7'd10;
    return {8'h30 + 8'(t), 8'h30 + 8'(o)};
  endfunction

  state_e        state_q, state_d, ret_q, ret_d;
  op_e           op_q, op_d;
  logic [7:0]    ch_q, ch_d;
  logic [CW-1:0] cur_q, cur_d, size_q, size_d, idx_q, idx_d, end_q, end_d;
  logic [CW-1:0] mv_n_q, mv_n_d;
  logic [7:0]    mv_dir_q, mv_dir_d;
  logic [2:0]    mv_step_q, mv_step_d;
  logic [2:0]    seq_ptr_q, seq_ptr_d;
  logic [3:0]    seq_end_q, seq_end_d;
  kind_e         kind_q, kind_d;
  logic [5:0]    cnt_q, cnt_d;
  res_t          hold_q, hold_d;
  logic          hold_v_q, hold_v_d;
  logic          out_v_q, out_v_d;
  res_t          out_q, out_d;
  logic          out_last_q, out_last_d;

  logic          adv;
  logic          emit_v;
  res_t          emit_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd, rdata;
  logic [6:0]    size7, lim7;
  logic [15:0]   digits;

  tle_ram #(.WIDTH(8), .DEPTH(LINE_LEN)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wa),
    .wdata_i(wd),
    .raddr_i(idx_d[AW-1:0]),
    .rdata_o(rdata)
  );

  assign adv    = !out_v_q || m_axis_tready_i;
  assign size7  = 7'(size_q);
  assign lim7   = (7'(line_limit_i) < 7'(LINE_LEN)) ? 7'(line_limit_i) : 7'(LINE_LEN);
  assign digits = dec_digits(7'(mv_n_q));

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    op_d       = op_q;
    ch_d       = ch_q;
    cur_d      = cur_q;
    size_d     = size_q;
    idx_d      = idx_q;
    end_d      = end_q;
    mv_n_d     = mv_n_q;
    mv_dir_d   = mv_dir_q;
    mv_step_d  = mv_step_q;
    seq_ptr_d  = seq_ptr_q;
    seq_end_d  = seq_end_q;
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_v_d    = (out_v_q && !m_axis_tready_i);
    op_pop_o   = 1'b0;
    emit_v     = 1'b0;
    emit_r     = '{data: 8'h00, kind: K_ECHO, len: 6'd0};
    we         = 1'b0;
    wa         = idx_q[AW-1:0];
    wd         = rdata;

    if (adv) begin
      unique case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            op_pop_o  = 1'b1;
            cnt_d     = 6'd0;
            op_d      = op_i.op;
            ch_d      = op_i.ch;
            mv_step_d = 3'd0;
            state_d   = ST_FIN;
            unique case (op_i.op)
              OP_RIGHT, OP_DEL: begin
                if (cur_q < size_q) begin
                  idx_d   = cur_q;
                  end_d   = CW'(cur_q + 1'b1);
                  kind_d  = K_ECHO;
                  cur_d   = CW'(cur_q + 1'b1);
                  ret_d   = (op_i.op == OP_DEL) ? ST_BS : ST_FIN;
                  state_d = ST_LOOP;
                end
              end
              OP_LEFT: begin
                if (cur_q != '0) begin
                  cur_d     = CW'(cur_q - 1'b1);
                  seq_ptr_d = SeqBs;
                  seq_end_d = 4'(SeqBs) + 4'd1;
                  ret_d     = ST_FIN;
                  state_d   = ST_SEQ;
                end
              end
              OP_BS: state_d = ST_BS;
              OP_ENTER: begin
                seq_ptr_d = SeqCrLf;
                seq_end_d = 4'(SeqCrLf) + 4'd2;
                ret_d     = ST_ENT;
                state_d   = ST_SEQ;
              end
              OP_CANCEL: begin
                seq_ptr_d = SeqCancel;
                seq_end_d = 4'(SeqCancel) + 4'd4;
                ret_d     = ST_MARK;
                state_d   = ST_SEQ;
              end
              OP_HOME: begin
                mv_n_d   = cur_q;
                mv_dir_d = ChUpperD;
                cur_d    = '0;
                state_d  = ST_MOVE;
              end
              OP_END: begin
                mv_n_d   = CW'(size_q - cur_q);
                mv_dir_d = ChUpperC;
                cur_d    = size_q;
                state_d  = ST_MOVE;
              end
              OP_INSERT: begin
                if (size7 < lim7) begin
                  if (size_q > cur_q) begin
                    idx_d   = CW'(size_q - 1'b1);
                    state_d = ST_SHR;
                  end else begin
                    state_d = ST_PUT;
                  end
                end
              end
            endcase
          end
        end
        ST_LOOP: begin
          emit_v = 1'b1;
          emit_r = '{data: rdata, kind: kind_q, len: 6'd0};
          if (CW'(idx_q + 1'b1) < end_q) begin
            idx_d = CW'(idx_q + 1'b1);
          end else begin
            state_d = ret_q;
          end
        end
        ST_SEQ: begin
          emit_v    = 1'b1;
          emit_r    = '{data: seq_byte(seq_ptr_q), kind: K_ECHO, len: 6'd0};
          seq_ptr_d = seq_ptr_q + 3'd1;
          if (4'(seq_ptr_q) + 4'd1 == seq_end_q) begin
            state_d = ret_q;
          end
        end
        ST_MOVE: begin
          if (mv_n_q == '0) begin
            state_d = ST_FIN;
          end else begin
            emit_v    = 1'b1;
            mv_step_d = mv_step_q + 3'd1;
            priority case (mv_step_q)
              3'd0:    emit_r.data = ChEsc;
              3'd1:    emit_r.data = 8'h5b;
              3'd2:    emit_r.data = digits[15:8];
              3'd3:    emit_r.data = digits[7:0];
              default: begin
                emit_r.data = mv_dir_q;
                state_d     = ST_FIN;
              end
            endcase
          end
        end
        ST_SHR: begin
          // make room: store[idx+1] <= store[idx], walking down to the cursor
          we = 1'b1;
          wa = AW'(idx_q + 1'b1);
          if (idx_q > cur_q) begin
            idx_d = CW'(idx_q - 1'b1);
          end else begin
            state_d = ST_PUT;
          end
        end
        ST_PUT: begin
          we      = 1'b1;
          wa      = cur_q[AW-1:0];
          wd      = ch_q;
          cur_d   = CW'(cur_q + 1'b1);
          size_d  = CW'(size_q + 1'b1);
          state_d = ST_CH;
        end
        ST_CH: begin
          emit_v    = 1'b1;
          emit_r    = '{data: ch_q, kind: K_ECHO, len: 6'd0};
          mv_n_d    = CW'(size_q - cur_q);
          mv_dir_d  = ChUpperD;
          mv_step_d = 3'd0;
          if (cur_q < size_q) begin
            idx_d   = cur_q;
            end_d   = size_q;
            kind_d  = K_ECHO;
            ret_d   = ST_MOVE;
            state_d = ST_LOOP;
          end else begin
            state_d = ST_MOVE;
          end
        end
        ST_BS: begin
          if (cur_q == '0) begin
            state_d = ST_FIN;
          end else if (cur_q < size_q) begin
            idx_d   = cur_q;
            state_d = ST_SHL;
          end else begin
            state_d = ST_BS2;
          end
        end
        ST_SHL: begin
          we = 1'b1;
          wa = AW'(idx_q - 1'b1);
          if (CW'(idx_q + 1'b1) < size_q) begin
            idx_d = CW'(idx_q + 1'b1);
          end else begin
            state_d = ST_BS2;
          end
        end
        ST_BS2: begin
          cur_d     = CW'(cur_q - 1'b1);
          size_d    = CW'(size_q - 1'b1);
          seq_ptr_d = SeqBs;
          seq_end_d = 4'(SeqBs) + 4'd1;
          ret_d     = ST_BS3;
          state_d   = ST_SEQ;
        end
        ST_BS3: begin
          if (cur_q == size_q) begin
            seq_ptr_d = SeqSp;
            seq_end_d = 4'(SeqSp) + 4'd2;
            ret_d     = ST_FIN;
            state_d   = ST_SEQ;
          end else begin
            idx_d   = cur_q;
            end_d   = size_q;
            kind_d  = K_ECHO;
            ret_d   = ST_BS4;
            state_d = ST_LOOP;
          end
        end
        ST_BS4: begin
          seq_ptr_d = SeqSp;
          seq_end_d = 4'(SeqSp) + 4'd1;
          mv_n_d    = CW'(size_q - cur_q + 1'b1);
          mv_dir_d  = ChUpperD;
          mv_step_d = 3'd0;
          ret_d     = ST_MOVE;
          state_d   = ST_SEQ;
        end
        ST_ENT: begin
          if (size_q != '0) begin
            idx_d   = '0;
            end_d   = size_q;
            kind_d  = K_LINE;
            ret_d   = ST_MARK;
            state_d = ST_LOOP;
          end else begin
            state_d = ST_MARK;
          end
        end
        ST_MARK: begin
          emit_v = 1'b1;
          if (op_q == OP_ENTER) begin
            emit_r = '{data: 8'h00, kind: K_DONE, len: 6'(size_q)};
          end else begin
            emit_r = '{data: 8'h00, kind: K_CANCEL, len: 6'd0};
          end
          cur_d   = '0;
          size_d  = '0;
          state_d = ST_FIN;
        end
        ST_FIN: begin
          // the held result is the last one of this byte
          if (hold_v_q) begin
            out_v_d    = 1'b1;
            out_d      = hold_q;
            out_last_d = 1'b1;
            hold_v_d   = 1'b0;
          end
          state_d = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase

      if (emit_v && (cnt_q < 6'(MaxResults))) begin
        cnt_d    = cnt_q + 6'd1;
        hold_d   = emit_r;
        hold_v_d = 1'b1;
        if (hold_v_q) begin
          out_v_d    = 1'b1;
          out_d      = hold_q;
          out_last_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_FIN;
      cur_q    <= '0;
      size_q   <= '0;
      cnt_q    <= 6'd0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      cur_q    <= cur_d;
      size_q   <= size_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ch_q       <= ch_d;
    idx_q      <= idx_d;
    end_q      <= end_d;
    mv_n_q     <= mv_n_d;
    mv_dir_q   <= mv_dir_d;
    mv_step_q  <= mv_step_d;
    seq_ptr_q  <= seq_ptr_d;
    seq_end_q  <= seq_end_d;
    kind_q     <= kind_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {2'b00, out_q.len, out_q.data};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;

  a_cur_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= size_q) else $error("cursor past end of line");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_v_q) else $error("result left behind at idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'(MaxResults)) else $error("result count overrun");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(size_q) <= 7'(LINE_LEN)) else $error("line size beyond store");

endmodule

### tb/terminal_line_editor_top_test.sv
// Testbench for the terminal line editor: directed and random byte streams vs. a predictor.
`timescale 1ns / 1ps
module terminal_line_editor_top_test;
  import tle_pkg::*;

  localparam int unsigned LineLen = 32;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [5:0] len;
    logic       last;
  } echo_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  terminal_line_editor_top #(.LINE_LEN(LineLen)) uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  ed_store [LineLen];
  int unsigned ed_cursor, ed_size, ed_limit;
  bit          ed_esc;
  echo_item_t  echo_q [$];
  echo_item_t  step_buf [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned ed_burst = 0;

  task automatic push_res(logic [7:0] b, logic [1:0] k, logic [5:0] l);
    echo_item_t r;
    if (step_buf.size() >= MaxResults) return;
    r.data = b; r.kind = k; r.len = l; r.last = 1'b0;
    step_buf.push_back(r);
  endtask

  task automatic cursor_move(logic [7:0] dir, int unsigned n);
    if (n == 0) return;
    push_res(ChEsc, K_ECHO, 0);
    push_res("[", K_ECHO, 0);
    push_res(8'(8'h30 + (n / 10) % 10), K_ECHO, 0);
    push_res(8'(8'h30 + n % 10), K_ECHO, 0);
    push_res(dir, K_ECHO, 0);
  endtask

  task automatic rub_out();
    if (ed_cursor == 0) return;
    for (int unsigned i = ed_cursor; i < ed_size; i++) ed_store[i-1] = ed_store[i];
    push_res(ChBs, K_ECHO, 0);
    ed_cursor--; ed_size--;
    if (ed_cursor == ed_size) begin
      push_res(ChSpace, K_ECHO, 0);
      push_res(ChBs, K_ECHO, 0);
    end else begin
      for (int unsigned i = ed_cursor; i < ed_size; i++) push_res(ed_store[i], K_ECHO, 0);
      push_res(ChSpace, K_ECHO, 0);
      cursor_move(ChUpperD, ed_size - ed_cursor + 1);
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    int unsigned code;
    int unsigned lim;
    step_buf.delete();
    if (ed_esc) begin
      ed_esc = 0;
      code = 32'h1b00 | b;
    end else if (b == ChEsc) begin
      ed_esc = 1;
      return;
    end else code = b;
    lim = (ed_limit < LineLen) ? ed_limit : LineLen;
    if (code == ChCtrlF || code == 32'h1b43) begin
      if (ed_cursor < ed_size) begin
        push_res(ed_store[ed_cursor], K_ECHO, 0); ed_cursor++;
      end
    end else if (code == ChCtrlB || code == 32'h1b44) begin
      if (ed_cursor > 0) begin
        push_res(ChBs, K_ECHO, 0); ed_cursor--;
      end
    end else if (code == 32'h1b34) begin
      if (ed_cursor < ed_size) begin
        push_res(ed_store[ed_cursor], K_ECHO, 0); ed_cursor++;
        rub_out();
      end
    end else if (code == ChBs) begin
      rub_out();
    end else if (code == ChLf || code == ChCr) begin
      push_res(ChCr, K_ECHO, 0);
      push_res(ChLf, K_ECHO, 0);
      for (int unsigned i = 0; i < ed_size; i++) push_res(ed_store[i], K_LINE, 0);
      push_res(0, K_DONE, 6'(ed_size));
      ed_cursor = 0; ed_size = 0;
    end else if (code == ChCtrlC) begin
      push_res("^", K_ECHO, 0);
      push_res("C", K_ECHO, 0);
      push_res(ChCr, K_ECHO, 0);
      push_res(ChLf, K_ECHO, 0);
      push_res(0, K_CANCEL, 0);
      ed_cursor = 0; ed_size = 0;
    end else if (code == ChCtrlA) begin
      cursor_move(ChUpperD, ed_cursor); ed_cursor = 0;
    end else if (code == ChCtrlE) begin
      cursor_move(ChUpperC, ed_size - ed_cursor); ed_cursor = ed_size;
    end else if (code >= ChSpace && code <= ChTilde) begin
      if (ed_size < lim) begin
        for (int unsigned i = ed_size; i > ed_cursor; i--) ed_store[i] = ed_store[i-1];
        ed_store[ed_cursor] = 8'(code);
        ed_size++; ed_cursor++;
        push_res(8'(code), K_ECHO, 0);
        for (int unsigned i = ed_cursor; i < ed_size; i++) push_res(ed_store[i], K_ECHO, 0);
        cursor_move(ChUpperD, ed_size - ed_cursor);
      end
    end
    if (step_buf.size() > 0) step_buf[$].last = 1'b1;
    foreach (step_buf[i]) echo_q.push_back(step_buf[i]);
  endtask

  // sends one byte in bursts with random gaps; valid stays high inside a burst
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (ed_burst == 0) begin
      ed_burst = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    ed_burst--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_byte(b);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
    repeat (2 * LineLen + 20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [5:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ed_limit = v;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic test_directed();
    send_str("ab");
    send_byte(ChTilde); send_byte(ChSpace);
    send_byte(ChCtrlB); send_byte(ChCtrlB); send_byte("x");
    send_byte(ChCtrlA); send_byte(ChCtrlA); send_byte(ChCtrlE); send_byte(ChCtrlE);
    send_byte(ChCtrlF); send_byte(ChCtrlB); send_byte(ChBs);
    send_byte(ChEsc); send_byte(ChUpperD); send_byte(ChEsc); send_byte(ChUpperC);
    send_byte(ChEsc); send_byte(ChFour); send_byte(ChCtrlA);
    send_byte(ChEsc); send_byte(ChFour);
    send_byte(ChEsc); send_byte(ChEsc); send_byte(8'hff); send_byte(8'h00);
    send_byte(ChCr); send_byte(ChBs); send_byte(ChCtrlF);
    send_str("zz"); send_byte(ChCtrlC); send_byte(ChLf);
  endtask

  task automatic test_limit_edges();
    write_limit(6'd0);
    send_str("abc"); send_byte(ChCr);
    write_limit(6'd1);
    send_str("qr"); send_byte(ChCr);
    write_limit(6'd63);
    repeat (34) send_byte(8'($urandom_range(8'h20, 8'h7e)));
    send_byte(ChCtrlA); send_byte(ChEsc); send_byte(ChFour); send_byte(ChCr);
  endtask

  task automatic test_random(int unsigned n);
    logic [7:0] b;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: b = 8'($urandom_range(8'h20, 8'h7e));
        8: b = ChBs;
        9: b = ($urandom_range(0, 1)) ? ChCtrlB : ChCtrlF;
        10: b = ($urandom_range(0, 1)) ? ChCtrlA : ChCtrlE;
        11, 12: begin
          send_byte(ChEsc);
          case ($urandom_range(0, 3))
            0: b = ChUpperC;
            1: b = ChUpperD;
            2: b = ChFour;
            default: b = 8'($urandom);
          endcase
        end
        13: b = ($urandom_range(0, 1)) ? ChCr : ChLf;
        14: b = ($urandom_range(0, 3) == 0) ? ChCtrlC : ChBs;
        default: b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7e));
      endcase
      send_byte(b);
    end
    send_byte(ChCr);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    echo_item_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.data = m_axis_tdata_o[7:0];
      got.len = m_axis_tdata_o[13:8];
      got.kind = m_axis_tuser_o;
      got.last = m_axis_tlast_o;
      if (echo_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = echo_q.pop_front();
        if (got !== want || m_axis_tdata_o[15:14] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp data %h kind %0d len %0d last %0b, ",
                      "got data %h kind %0d len %0d last %0b"},
                     want.data, want.kind, want.len, want.last,
                     got.data, got.kind, got.len, got.last);
        end
      end
    end
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
      default: m_axis_tready_i <= (cycles % 7 < 2);
    endcase
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    ed_cursor = 0; ed_size = 0; ed_esc = 0; ed_limit = 32;
    foreach (ed_store[i]) ed_store[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limit_edges();
    write_limit(6'd5);
    test_random(40);
    write_limit(6'd32);
    test_random(140);
    write_limit(6'd12);
    test_random(35);
    drain();
    if (mismatches == 0 && echo_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
